@@ sv/bfs_adjacency_matrix_assert.svh @@
// Assertion macros for the BFS block.
`ifndef BFS_ADJACENCY_MATRIX_ASSERT_SVH
`define BFS_ADJACENCY_MATRIX_ASSERT_SVH

// Implication checked every clock, quiet in reset.
`define BFS_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Property checked every clock, quiet in reset.
`define BFS_ASSERT_ALW(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

@@ sv/bfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bfs_pkg
// Types and constants shared by the BFS block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bfs_pkg;
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_INIT,
        ST_DEQ,
        ST_FETCH,
        ST_ROW,
        ST_SCAN,
        ST_EMIT
    } t_state;
endpackage
`default_nettype wire

@@ sv/bfs_row_mem.sv @@
// ----------------------------------------------------------------------------
// bfs_row_mem
// Adjacency row memory: one port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bfs_row_mem #(
    parameter int AW = 6,
    parameter int DW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    // read first: read data is the old word on a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ sv/bfs_adjacency_matrix.sv @@
// Channel | Dir | Handshake                 | Payload
// input   | in  | i_valid / o_ready         | i_op, i_from_vertex, i_to_vertex
// result  | out | o_valid / i_ready         | o_vertex .. o_last
// config  | in  | i_cfg_we                  | i_cfg_wdata (vertex_count)
// Clear: zeroes every matrix row (MAX_VERTICES) in turn. Add edge: row read, then write.
// Search: an init step, then per dequeued vertex a queue read, row read, row latch and
// a scan of one column a cycle, then one final empty-queue check, then one result a
// cycle while ready is high.
// Reset is synchronous, active low; after reset a sweep clears all MAX_VERTICES adjacency
// rows, during which no transaction is accepted. A stalled result holds emit.
// ----------------------------------------------------------------------------
// bfs_adjacency_matrix
// Breadth-first search over an adjacency bit matrix held in a row memory, with edge add and clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bfs_adjacency_matrix #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_op,
    input  wire logic [5:0] i_from_vertex,
    input  wire logic [5:0] i_to_vertex,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [5:0]      o_vertex,
    output logic            o_reached,
    output logic [5:0]      o_distance,
    output logic            o_has_parent,
    output logic [5:0]      o_parent,
    output logic            o_last
);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] NMAX = CW'(MAX_VERTICES);

    bfs_pkg::t_state r_state, n_state;
    logic [6:0]    r_count;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_idx, n_idx;
    logic [1:0]    r_op;
    logic [5:0]    r_a, r_b;
    logic [MAX_VERTICES-1:0] r_vis, n_vis;
    logic [CW-1:0] r_head, n_head, r_tail, n_tail;
    logic [AW-1:0] r_u;
    logic [5:0]    r_du;
    logic [MAX_VERTICES-1:0] r_row;
    logic [5:0]    r_out_dist;
    logic [AW-1:0] r_out_par;

    // per-vertex tables and queue
    logic [5:0]    r_dist [MAX_VERTICES];
    logic [AW-1:0] r_par  [MAX_VERTICES];
    logic [AW-1:0] r_q    [MAX_VERTICES];

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [MAX_VERTICES-1:0] mem_wdata, mem_rdata;

    logic [AW-1:0] idx_a;
    logic          a_ok, b_ok, bit_new, out_fire;

    assign idx_a  = r_idx[AW-1:0];
    assign a_ok   = {1'b0, r_a} < 7'(r_n);
    assign b_ok   = {1'b0, r_b} < 7'(r_n);
    assign bit_new = r_row[idx_a] && !r_vis[idx_a];
    assign out_fire = o_valid && i_ready;

    bfs_row_mem #(.AW(AW), .DW(MAX_VERTICES)) u_rows (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    // effective vertex count
    always_comb begin
        r_n = (r_count > 7'(NMAX)) ? NMAX : r_count[CW-1:0];
    end

    // memory port
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_a[AW-1:0];
        mem_wdata = mem_rdata | (MAX_VERTICES'(1) << r_b[AW-1:0]);
        unique case (r_state)
            bfs_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = idx_a;
                mem_wdata = '0;
            end
            bfs_pkg::ST_FETCH: mem_addr = r_u;
            bfs_pkg::ST_INIT: begin
                // add edge: write on the INIT pass with r_idx nonzero, after the row read
                mem_we = (r_op == bfs_pkg::OP_ADD) && (r_idx != '0) && a_ok && b_ok;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_head  = r_head;
        n_tail  = r_tail;
        n_vis   = r_vis;
        unique case (r_state)
            bfs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_idx = '0;
                    unique case (i_op)
                        bfs_pkg::OP_CLEAR:  n_state = bfs_pkg::ST_CLEAR;
                        bfs_pkg::OP_ADD,
                        bfs_pkg::OP_SEARCH: n_state = bfs_pkg::ST_INIT;
                        default:            n_state = bfs_pkg::ST_IDLE;
                    endcase
                end
            end
            bfs_pkg::ST_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == NMAX - 1'b1) begin
                    n_state = bfs_pkg::ST_IDLE;
                end
            end
            bfs_pkg::ST_INIT: begin
                if (r_op == bfs_pkg::OP_ADD) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx != '0) n_state = bfs_pkg::ST_IDLE;
                end else begin
                    n_vis  = '0;
                    n_head = '0;
                    n_tail = '0;
                    n_idx  = '0;
                    if (a_ok) begin
                        n_vis[r_a[AW-1:0]] = 1'b1;
                        n_tail = CW'(1);
                        n_state = bfs_pkg::ST_DEQ;
                    end else begin
                        n_state = (r_n == '0) ? bfs_pkg::ST_IDLE : bfs_pkg::ST_EMIT;
                    end
                end
            end
            bfs_pkg::ST_DEQ: begin
                if (r_head < r_tail) begin
                    n_head  = r_head + 1'b1;
                    n_state = bfs_pkg::ST_FETCH;
                end else begin
                    n_idx   = '0;
                    n_state = bfs_pkg::ST_EMIT;
                end
            end
            bfs_pkg::ST_FETCH: begin
                n_state = bfs_pkg::ST_ROW;
            end
            bfs_pkg::ST_ROW: begin
                n_idx   = '0;
                n_state = bfs_pkg::ST_SCAN;
            end
            bfs_pkg::ST_SCAN: begin
                if (bit_new) begin
                    n_vis[idx_a] = 1'b1;
                    if (r_tail < NMAX) n_tail = r_tail + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == r_n - 1'b1) n_state = bfs_pkg::ST_DEQ;
            end
            bfs_pkg::ST_EMIT: begin
                if (out_fire) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == r_n - 1'b1) n_state = bfs_pkg::ST_IDLE;
                end
            end
            default: n_state = bfs_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready      = (r_state == bfs_pkg::ST_IDLE);
        o_valid      = (r_state == bfs_pkg::ST_EMIT);
        o_vertex     = 6'(r_idx);
        o_reached    = r_vis[idx_a];
        o_distance   = r_vis[idx_a] ? r_out_dist : 6'd0;
        o_has_parent = r_vis[idx_a] && (r_out_dist != 6'd0);
        o_parent     = o_has_parent ? 6'(r_out_par) : 6'd0;
        o_last       = (r_idx == r_n - 1'b1);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfs_pkg::ST_CLEAR;
            r_idx   <= '0;
            r_count <= 7'd64;
            r_vis   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_vis   <= n_vis;
            r_head  <= n_head;
            r_tail  <= n_tail;
            if (i_cfg_we) r_count <= i_cfg_wdata;
        end
    end

    // payload: item capture, tables, queue
    always_ff @(posedge i_clk) begin
        if (r_state == bfs_pkg::ST_IDLE && i_valid) begin
            r_op <= i_op;
            r_a  <= i_from_vertex;
            r_b  <= i_to_vertex;
        end
        if (r_state == bfs_pkg::ST_INIT && r_op == bfs_pkg::OP_SEARCH && a_ok) begin
            r_q[0]               <= r_a[AW-1:0];
            r_dist[r_a[AW-1:0]]  <= 6'd0;
        end
        // queue read, then the dequeued vertex's distance
        if (r_state == bfs_pkg::ST_DEQ) begin
            r_u <= r_q[r_head[AW-1:0]];
        end
        if (r_state == bfs_pkg::ST_FETCH) begin
            r_du <= r_dist[r_u];
        end
        if (r_state == bfs_pkg::ST_ROW) begin
            r_row <= mem_rdata;
        end
        if (r_state == bfs_pkg::ST_SCAN && bit_new) begin
            r_dist[idx_a] <= r_du + 6'd1;
            r_par[idx_a]  <= r_u;
            if (r_tail < NMAX) r_q[r_tail[AW-1:0]] <= idx_a;
        end
        // registered table reads for the result port, addressed ahead by n_idx
        r_out_dist <= r_dist[n_idx[AW-1:0]];
        r_out_par  <= r_par[n_idx[AW-1:0]];
    end

    `include "bfs_adjacency_matrix_assert.svh"
    `BFS_ASSERT_IMP(a_out_only_emit, i_clk, i_rst_n, o_valid, r_state == bfs_pkg::ST_EMIT, "valid outside emit")
    `BFS_ASSERT_ALW(a_head_le_tail, i_clk, i_rst_n, r_head <= r_tail, "queue head passed tail")
    `BFS_ASSERT_IMP(a_no_ready_busy, i_clk, i_rst_n, o_valid, !o_ready, "ready during emit")
endmodule
`default_nettype wire
